@@ src/mrpg_pkg.sv @@
`timescale 1ns / 1ps

package mrpg_pkg;

    // Number of request slots and the width of a slot index.
    localparam int unsigned SlotCount = 5;
    localparam int unsigned SlotWidth = 3;

    // Configuration register indexes.
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 49;
    localparam logic [CfgIndexWidth-1:0] REG_POLL_ENABLE   = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_POLL_INTERVAL = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_SLOT_0        = 3'd2;

    // Reset value of the poll interval in milliseconds.
    localparam logic [15:0] DEFAULT_INTERVAL = 16'd5000;

    // CRC-16/MODBUS: reflected polynomial and initial value.
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Position of the last byte covered by the CRC and of the two CRC bytes.
    localparam logic [2:0] BODY_LAST_POS = 3'd5;
    localparam logic [2:0] CRC_LO_POS    = 3'd6;
    localparam logic [2:0] CRC_HI_POS    = 3'd7;

    // One request slot as it is packed in its configuration register.
    typedef struct packed {
        logic        used;
        logic [7:0]  id;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] qty;
    } slot_frame_t;

    // Configuration seen by the poll logic.
    typedef struct packed {
        logic                           enable;
        logic [15:0]                    interval;
        slot_frame_t [SlotCount-1:0]    slots;
    } cfg_t;

    // One request handed from the poll logic to the serializer.
    typedef struct packed {
        logic [SlotWidth-1:0] slot;
        logic [47:0]          body;
    } req_t;

    // One byte of CRC-16/MODBUS, processed LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

@@ src/modbus_rtu_poll_request_generator_unit.sv @@
`timescale 1ns / 1ps

// Modbus RTU poll request generator. Each input beat carries one tick flag:
// a one means a millisecond has passed, a zero means no time passes, and every
// beat also runs the poll check. Ticks are counted toward poll_interval_ms and
// the count holds at the interval while polling is disabled. Once polling is
// enabled and the interval has elapsed, the count restarts and the next used
// request slot, searched round robin from the slot pointer, is sent as an
// 8-beat request: id, function, address high and low, quantity high and low,
// then the CRC-16/MODBUS low and high bytes, with last_byte marking the final
// beat. A poll with no used slot emits nothing. Input beats are taken one per
// cycle as long as no request is waiting for the serializer; a request that
// fires while another is being sent is held in a one-deep buffer, and ticks
// stall until the serializer picks it up. The serializer sends one byte per
// cycle while the output is not stalled and folds each body byte into the CRC
// as it goes; the first byte of a request passes through the request buffer,
// the serializer's frame register and the output register. Configuration
// writes never push back and are expected only while the block is idle.

module modbus_rtu_poll_request_generator_unit
    import mrpg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     tick,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               tx_byte,
    output logic [2:0]               byte_position,
    output logic [SlotWidth-1:0]     slot_number,
    output logic                     last_byte
);

    cfg_t cfg;
    req_t req;
    logic req_valid;
    logic req_take;

    // Register file for the enable, the interval and the five request slots.
    mrpg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Tick counter, slot pointer, slot search and the one-deep request buffer.
    mrpg_poll u_poll (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .tick      (tick),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take)
    );

    // Byte serializer with the running CRC and the output register.
    mrpg_ser u_ser (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req           (req),
        .req_take      (req_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_byte       (tx_byte),
        .byte_position (byte_position),
        .slot_number   (slot_number),
        .last_byte     (last_byte)
    );

    // Within a request, every taken beat except the last is followed at once
    // by the next byte position of the same slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_byte) |=>
            (out_valid && (byte_position == $past(byte_position) + 3'd1)
             && (slot_number == $past(slot_number))))
        else $error("request beats not contiguous");

    // A request always starts at its first byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (byte_position == 3'd0))
        else $error("request started mid-frame");

    // The final-byte flag marks exactly the CRC high byte, and the slot number is in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((last_byte == (byte_position == CRC_HI_POS))
                       && (slot_number < SlotWidth'(SlotCount))))
        else $error("bad last_byte or slot number");

endmodule

@@ src/mrpg_cfg.sv @@
`timescale 1ns / 1ps

module mrpg_cfg
    import mrpg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    output cfg_t                     cfg
);

    logic                        enable_reg;
    logic [15:0]                 interval_reg;
    slot_frame_t [SlotCount-1:0] slot_reg;

    // Writes are always taken, so the port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            interval_reg <= DEFAULT_INTERVAL;
            slot_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POLL_ENABLE:
                begin
                    enable_reg <= cfg_data[0];
                end
                REG_POLL_INTERVAL:
                begin
                    interval_reg <= cfg_data[15:0];
                end
                default:
                begin
                    // Indexes past the last slot are ignored.
                    for (int i = 0; i < SlotCount; i++) begin
                        if (cfg_index == CfgIndexWidth'(REG_SLOT_0 + i))
                        begin
                            slot_reg[i] <= cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    assign cfg.enable   = enable_reg;
    assign cfg.interval = interval_reg;
    assign cfg.slots    = slot_reg;

endmodule

@@ src/mrpg_poll.sv @@
`timescale 1ns / 1ps

module mrpg_poll
    import mrpg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_stall,
    input  logic tick,
    output logic req_valid,
    output req_t req,
    input  logic req_take
);

    logic [15:0]          elapsed_reg;
    logic [15:0]          elapsed_next;
    logic [SlotWidth-1:0] next_slot_reg;
    logic [SlotWidth-1:0] next_slot_next;
    logic                 pend_valid_reg;
    req_t                 pend_reg;

    logic                 accept;
    logic [15:0]          elapsed_inc;
    logic                 fire;
    logic [SlotWidth:0]   cand_wide [SlotCount];
    logic [SlotWidth-1:0] cand      [SlotCount];
    logic                 found;
    logic [SlotWidth-1:0] sel;

    // A pending request blocks further ticks until the serializer takes it.
    assign in_stall = pend_valid_reg;
    assign accept   = in_valid && !pend_valid_reg;

    always_comb
    begin
        // The counter saturates at the interval.
        if (tick && (elapsed_reg < cfg.interval))
        begin
            elapsed_inc = elapsed_reg + 16'd1;
        end
        else
        begin
            elapsed_inc = elapsed_reg;
        end
        fire = cfg.enable && !(elapsed_inc < cfg.interval);
    end

    // Round-robin search starting at the slot pointer.
    always_comb
    begin
        for (int k = 0; k < SlotCount; k++) begin
            cand_wide[k] = {1'b0, next_slot_reg} + (SlotWidth+1)'(k);
            if (cand_wide[k] >= (SlotWidth+1)'(SlotCount))
            begin
                cand[k] = SlotWidth'(cand_wide[k] - (SlotWidth+1)'(SlotCount));
            end
            else
            begin
                cand[k] = cand_wide[k][SlotWidth-1:0];
            end
        end
        found = 1'b0;
        sel   = '0;
        for (int k = 0; k < SlotCount; k++) begin
            if (!found && cfg.slots[cand[k]].used)
            begin
                found = 1'b1;
                sel   = cand[k];
            end
        end
    end

    always_comb
    begin
        elapsed_next   = fire ? 16'd0 : elapsed_inc;
        next_slot_next = next_slot_reg;
        if (fire && found)
        begin
            if (sel == SlotWidth'(SlotCount - 1))
            begin
                next_slot_next = '0;
            end
            else
            begin
                next_slot_next = sel + SlotWidth'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg    <= '0;
            next_slot_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                elapsed_reg   <= elapsed_next;
                next_slot_reg <= next_slot_next;
            end
            if (accept && fire && found)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (req_take)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && fire && found)
        begin
            pend_reg.slot <= sel;
            pend_reg.body <= {cfg.slots[sel].id, cfg.slots[sel].func,
                              cfg.slots[sel].addr, cfg.slots[sel].qty};
        end
    end

    assign req_valid = pend_valid_reg;
    assign req       = pend_reg;

endmodule

@@ src/mrpg_ser.sv @@
`timescale 1ns / 1ps

module mrpg_ser
    import mrpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  req_t                 req,
    output logic                 req_take,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           tx_byte,
    output logic [2:0]           byte_position,
    output logic [SlotWidth-1:0] slot_number,
    output logic                 last_byte
);

    logic                 busy_reg;
    logic [2:0]           pos_reg;
    logic [15:0]          crc_reg;
    req_t                 frame_reg;

    logic                 out_valid_reg;
    logic [7:0]           tx_byte_reg;
    logic [2:0]           byte_position_reg;
    logic [SlotWidth-1:0] slot_number_reg;
    logic                 last_byte_reg;

    logic                 advance;
    logic [7:0]           byte_next;
    logic [15:0]          crc_next;

    assign advance  = !out_valid_reg || !out_stall;
    assign req_take = req_valid && (!busy_reg || (advance && (pos_reg == CRC_HI_POS)));

    always_comb
    begin
        case (pos_reg)
            3'd0:    byte_next = frame_reg.body[47:40];
            3'd1:    byte_next = frame_reg.body[39:32];
            3'd2:    byte_next = frame_reg.body[31:24];
            3'd3:    byte_next = frame_reg.body[23:16];
            3'd4:    byte_next = frame_reg.body[15:8];
            3'd5:    byte_next = frame_reg.body[7:0];
            3'd6:    byte_next = crc_reg[7:0];
            default: byte_next = crc_reg[15:8];
        endcase
        crc_next = crc16_byte(crc_reg, byte_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= busy_reg;
            end
            // A new request taken on the last byte of the previous one starts
            // right away at its first byte.
            if (req_take)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end
            else if (advance && busy_reg)
            begin
                pos_reg <= pos_reg + 3'd1;
                if (pos_reg == CRC_HI_POS)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && busy_reg)
        begin
            tx_byte_reg       <= byte_next;
            byte_position_reg <= pos_reg;
            slot_number_reg   <= frame_reg.slot;
            last_byte_reg     <= (pos_reg == CRC_HI_POS);
            if (!(pos_reg > BODY_LAST_POS))
            begin
                crc_reg <= crc_next;
            end
        end
        if (req_take)
        begin
            frame_reg <= req;
            crc_reg   <= CRC_INIT;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_byte       = tx_byte_reg;
    assign byte_position = byte_position_reg;
    assign slot_number   = slot_number_reg;
    assign last_byte     = last_byte_reg;

endmodule
